// File: rtl/core/snt_pkg.sv
// ----------------------------------------------------------------------------
// snt_pkg - shared types for the SCTP NAT table
// Entry layout, op codes, status codes and the per-cell control word.
// ----------------------------------------------------------------------------
package snt_pkg;

	// one translation entry (also used as the lookup key)
	typedef struct packed {
		logic [31:0] local_addr;
		logic [31:0] global_addr;
		logic [31:0] natted_addr;
		logic [15:0] local_port;
		logic [15:0] global_port;
		logic [15:0] natted_port;
		logic [31:0] local_vtag;
		logic [31:0] global_vtag;
	} entry_t;

	typedef enum logic [2:0] {
		OP_INSERT     = 3'd0,
		OP_OUTBOUND   = 3'd1,
		OP_INBOUND    = 3'd2,
		OP_SPECIAL    = 3'd3,
		OP_LOCAL_INIT = 3'd4,
		OP_LOCAL      = 3'd5,
		OP_REMOVE     = 3'd6
	} op_t;

	localparam logic [1:0] ST_HIT  = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// per-cell write control from the top level
	typedef struct packed {
		logic load_key;  // write the key (insert at tail)
		logic shift;     // take the neighbor's entry (compaction on remove)
	} cell_ctl_t;

endpackage

// File: rtl/core/snt_cell.sv
// ----------------------------------------------------------------------------
// snt_cell - one table slot
// Holds one entry, compares it with the current key, and on removal takes the
// entry of its upper neighbor so the table stays compact.
// ----------------------------------------------------------------------------
module snt_cell (
	input  logic               clk,
	input  snt_pkg::cell_ctl_t ctl,
	input  snt_pkg::op_t       op,
	input  snt_pkg::entry_t    key,
	input  snt_pkg::entry_t    nxt,
	input  logic               occupied,
	output snt_pkg::entry_t    entry,
	output logic               hit
);

	snt_pkg::entry_t entry_q;
	logic            match;

	always_ff @(posedge clk) begin
		if (ctl.load_key) begin
			entry_q <= key;
		end else if (ctl.shift) begin
			entry_q <= nxt;
		end
	end

	always_comb begin
		case (op)
			snt_pkg::OP_OUTBOUND: begin
				match = entry_q.local_addr == key.local_addr &&
					entry_q.local_port == key.local_port &&
					entry_q.global_addr == key.global_addr &&
					entry_q.global_port == key.global_port &&
					entry_q.global_vtag == key.global_vtag;
			end
			snt_pkg::OP_INBOUND: begin
				match = entry_q.global_addr == key.global_addr &&
					entry_q.global_port == key.global_port &&
					entry_q.natted_addr == key.natted_addr &&
					entry_q.natted_port == key.natted_port &&
					entry_q.local_vtag == key.local_vtag;
			end
			snt_pkg::OP_SPECIAL: begin
				match = entry_q.global_addr == key.global_addr &&
					entry_q.global_port == key.global_port &&
					entry_q.natted_addr == key.natted_addr &&
					entry_q.natted_port == key.natted_port &&
					entry_q.global_vtag == 32'd0;
			end
			snt_pkg::OP_LOCAL_INIT: begin
				match = entry_q.global_addr == key.global_addr &&
					entry_q.global_port == key.global_port &&
					entry_q.local_port == key.local_port;
			end
			snt_pkg::OP_LOCAL: begin
				match = entry_q.global_addr == key.global_addr &&
					entry_q.global_port == key.global_port &&
					entry_q.local_port == key.local_port &&
					entry_q.local_vtag == key.local_vtag;
			end
			snt_pkg::OP_REMOVE: begin
				// forward key or the key with the two ends swapped
				match = (entry_q.global_addr == key.global_addr &&
					entry_q.global_port == key.global_port &&
					entry_q.local_port == key.local_port &&
					entry_q.local_vtag == key.local_vtag) ||
					(entry_q.local_addr == key.global_addr &&
					entry_q.local_port == key.global_port &&
					entry_q.global_port == key.local_port &&
					entry_q.global_vtag == key.local_vtag);
			end
			default: begin
				match = 1'b0;
			end
		endcase
	end

	assign hit   = occupied & match;
	assign entry = entry_q;

endmodule

// File: rtl/core/snt_pick.sv
// ----------------------------------------------------------------------------
// snt_pick - first-match select
// Isolates the lowest hit, encodes its position, muxes its entry and builds
// the mask of slots at or above it (those that shift down on removal).
// ----------------------------------------------------------------------------
module snt_pick #(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  logic [DEPTH-1:0] hits,
	input  snt_pkg::entry_t  entries [DEPTH],
	output logic             any,
	output logic [IW-1:0]    index,
	output snt_pkg::entry_t  sel,
	output logic [DEPTH-1:0] at_or_above
);

	logic [DEPTH-1:0] first;

	// lowest set bit: x & -x
	assign first       = hits & (~hits + DEPTH'(1));
	assign at_or_above = ~(first - DEPTH'(1));
	assign any         = |hits;

	always_comb begin
		index = '0;
		sel   = '0;
		for (int i = 0; i < DEPTH; i++) begin
			index = index | (IW'(i) & {IW{first[i]}});
			sel   = sel | (entries[i] & {$bits(snt_pkg::entry_t){first[i]}});
		end
	end

endmodule

// File: rtl/core/sctp_nat_table_unit.sv
// ----------------------------------------------------------------------------
// sctp_nat_table_unit - ordered SCTP NAT translation table
// Insert, five first-match lookups and order-keeping remove over a row of
// entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command port: a word is taken on a rising edge with start high and busy
//   low (op plus the key fields). busy is high in the work cycle after that
//   edge, while the cells compare and the table is updated.
//   Result port: done is high for exactly one cycle, the cycle after the
//   command's work cycle, carrying status, slot and the entry fields. There
//   is no backpressure: the receiver must take the word in that cycle.
//   A new command can be taken on the edge that ends the done cycle, not
//   while the previous command is in its work cycle. In the compare cycle
//   every cell matches the key in parallel, the lowest hit is picked by one
//   carry chain over the row, and the row shifts or loads in the same cycle.
//   Insert appends at the tail (status full when all slots are used), remove
//   deletes the first forward or reversed match: that cell and each cell above
//   it take the next entry up. A miss returns status miss with all fields 0.
//   Reset empties the table (entry count to 0) and clears busy and done;
//   entry contents are not cleared, slots at or above the count never match.
// ----------------------------------------------------------------------------
module sctp_nat_table_unit #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [31:0] local_addr,
	input  logic [31:0] global_addr,
	input  logic [31:0] natted_addr,
	input  logic [15:0] local_port,
	input  logic [15:0] global_port,
	input  logic [15:0] natted_port,
	input  logic [31:0] local_vtag,
	input  logic [31:0] global_vtag,
	output logic        done,
	output logic [1:0]  status,
	output logic [3:0]  slot,
	output logic [31:0] out_local_addr,
	output logic [31:0] out_global_addr,
	output logic [31:0] out_natted_addr,
	output logic [15:0] out_local_port,
	output logic [15:0] out_global_port,
	output logic [15:0] out_natted_port,
	output logic [31:0] out_local_vtag,
	output logic [31:0] out_global_vtag
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// command capture
	logic            busy_q;
	snt_pkg::op_t    op_q;
	snt_pkg::entry_t key_q;

	// table state
	logic [CW-1:0]   count_q;

	// cell row
	snt_pkg::cell_ctl_t ctl     [TABLE_DEPTH];
	snt_pkg::entry_t    entries [TABLE_DEPTH];
	snt_pkg::entry_t    nxt     [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] hits;
	logic [TABLE_DEPTH-1:0] occ;

	// first-match results
	logic                   any_hit;
	logic [IW-1:0]          hit_idx;
	snt_pkg::entry_t        hit_entry;
	logic [TABLE_DEPTH-1:0] above;

	logic            full;
	logic            do_insert;
	logic            do_remove;
	logic            is_lookup;
	logic [IW+3:0]   idx_ext;
	logic [CW+3:0]   cnt_ext;

	// result register
	logic            done_q;
	logic [1:0]      status_q;
	logic [3:0]      slot_q;
	snt_pkg::entry_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start & ~busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			op_q  <= snt_pkg::op_t'(op);
			key_q <= '{local_addr: local_addr, global_addr: global_addr,
				natted_addr: natted_addr, local_port: local_port,
				global_port: global_port, natted_port: natted_port,
				local_vtag: local_vtag, global_vtag: global_vtag};
		end
	end

	// insert and compaction are decided in the work cycle (busy_q high)
	assign full      = count_q == CW'(TABLE_DEPTH);
	assign do_insert = busy_q && op_q == snt_pkg::OP_INSERT && !full;
	assign do_remove = busy_q && op_q == snt_pkg::OP_REMOVE && any_hit;
	assign is_lookup = op_q != snt_pkg::OP_INSERT;

	genvar g;
	generate
		for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
			assign occ[g]             = CW'(g) < count_q;
			assign ctl[g].load_key    = do_insert && count_q == CW'(g);
			assign ctl[g].shift       = do_remove && above[g];
			// top cell feeds itself; it leaves the occupied range anyway
			assign nxt[g] = (g == TABLE_DEPTH - 1) ? entries[g] :
				entries[(g == TABLE_DEPTH - 1) ? g : g + 1];

			snt_cell u_cell (
				.clk      (clk),
				.ctl      (ctl[g]),
				.op       (op_q),
				.key      (key_q),
				.nxt      (nxt[g]),
				.occupied (occ[g]),
				.entry    (entries[g]),
				.hit      (hits[g])
			);
		end
	endgenerate

	snt_pick #(
		.DEPTH (TABLE_DEPTH),
		.IW    (IW)
	) u_pick (
		.hits        (hits),
		.entries     (entries),
		.any         (any_hit),
		.index       (hit_idx),
		.sel         (hit_entry),
		.at_or_above (above)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= busy_q;
			if (do_insert) begin
				count_q <= count_q + CW'(1);
			end else if (do_remove) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// slot is the low 4 bits of the position
	assign idx_ext = {4'b0, hit_idx};
	assign cnt_ext = {4'b0, count_q};

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (!is_lookup) begin
				if (full) begin
					status_q <= snt_pkg::ST_FULL;
					slot_q   <= '0;
					res_q    <= '0;
				end else begin
					status_q <= snt_pkg::ST_HIT;
					slot_q   <= cnt_ext[3:0];
					res_q    <= key_q;
				end
			end else if (any_hit) begin
				status_q <= snt_pkg::ST_HIT;
				slot_q   <= idx_ext[3:0];
				res_q    <= hit_entry;
			end else begin
				// miss, also the unused op code
				status_q <= snt_pkg::ST_MISS;
				slot_q   <= '0;
				res_q    <= '0;
			end
		end
	end

	assign busy            = busy_q;
	assign done            = done_q;
	assign status          = status_q;
	assign slot            = slot_q;
	assign out_local_addr  = res_q.local_addr;
	assign out_global_addr = res_q.global_addr;
	assign out_natted_addr = res_q.natted_addr;
	assign out_local_port  = res_q.local_port;
	assign out_global_port = res_q.global_port;
	assign out_natted_port = res_q.natted_port;
	assign out_local_vtag  = res_q.local_vtag;
	assign out_global_vtag = res_q.global_vtag;

endmodule

// File: rtl/core/snt_chk.sv
// ----------------------------------------------------------------------------
// snt_chk - port-level checks for the SCTP NAT table
// Command/result timing and the zeroed result on miss or full.
// ----------------------------------------------------------------------------
module snt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [3:0]  slot,
	input logic [31:0] out_local_addr,
	input logic [31:0] out_global_vtag
);

	// each taken command yields exactly one result word, after its busy cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy ##1 done)
		else $error("command not answered on time");

	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a command");

	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == snt_pkg::ST_MISS || status == snt_pkg::ST_FULL) |->
		slot == 4'd0 && out_local_addr == 32'd0 && out_global_vtag == 32'd0)
		else $error("miss or full result not zeroed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3)
		else $error("undefined status code");

endmodule

bind sctp_nat_table_unit snt_chk u_snt_chk (.*);
